FILE: rtl/nbs_pkg.sv
// shared types, register codes and the exp2 table for the box suppression step
package nbs_pkg;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int IOU_BITS = 16;
  localparam int IOU_FRAC = 15;
  localparam int X_BITS = 26;
  localparam int SQ_BITS = 32;
  localparam int SIG_DEN_BITS = 22;
  localparam int W_BITS = 17;
  localparam int IDX_BITS = 12;
  localparam int CLASS_BITS = 8;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] IOU_THR_RST = 16'd16384;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BEST_X1    = 3'd0,
    CFG_BEST_Y1    = 3'd1,
    CFG_BEST_X2    = 3'd2,
    CFG_BEST_Y2    = 3'd3,
    CFG_BEST_CLASS = 3'd4,
    CFG_IOU_THR    = 3'd5,
    CFG_SCORE_THR  = 3'd6,
    CFG_SIGMA      = 3'd7
  } cfg_idx_t;

  // 2^(-k/16) in q16
  function automatic logic [W_BITS-1:0] exp2_q16(input logic [4:0] k);
    logic [W_BITS-1:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55110;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/nbs_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, side data carried along
module nbs_div_pipe #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 22,
  parameter int Q_W    = 26,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [Q_W-1:0]    out_quot,
  output logic [SIDE_W-1:0] out_side
);

  logic [Q_W-1:0]    vld_r;
  logic [DEN_W-1:0]  rem_r  [Q_W];
  logic [Q_W-1:0]    lq_r   [Q_W];
  logic [DEN_W-1:0]  den_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  logic [DEN_W-1:0]  rem_in  [Q_W];
  logic [Q_W-1:0]    lq_in   [Q_W];
  logic [DEN_W-1:0]  den_in  [Q_W];
  logic [SIDE_W-1:0] side_in [Q_W];
  logic [DEN_W:0]    trial   [Q_W];
  logic [Q_W-1:0]    ge;
  logic [DEN_W-1:0]  rem_nxt [Q_W];
  logic [Q_W-1:0]    lq_nxt  [Q_W];

  always_comb begin
    rem_in[0]  = DEN_W'(in_num[NUM_W-1:Q_W]);
    lq_in[0]   = in_num[Q_W-1:0];
    den_in[0]  = in_den;
    side_in[0] = in_side;
    for (int s = 1; s < Q_W; s++) begin
      rem_in[s]  = rem_r[s-1];
      lq_in[s]   = lq_r[s-1];
      den_in[s]  = den_r[s-1];
      side_in[s] = side_r[s-1];
    end
    for (int s = 0; s < Q_W; s++) begin
      trial[s]   = {rem_in[s], lq_in[s][Q_W-1]};
      ge[s]      = trial[s] >= {1'b0, den_in[s]};
      rem_nxt[s] = ge[s] ? DEN_W'(trial[s] - {1'b0, den_in[s]}) : DEN_W'(trial[s]);
      lq_nxt[s]  = {lq_in[s][Q_W-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Q_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < Q_W; s++) begin
      rem_r[s]  <= rem_nxt[s];
      lq_r[s]   <= lq_nxt[s];
      den_r[s]  <= den_in[s];
      side_r[s] <= side_in[s];
    end
  end

  assign out_vld  = vld_r[Q_W-1];
  assign out_quot = lq_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

endmodule

FILE: rtl/nms_box_suppress_step_unit.sv
// top level: one soft/hard non-maximum suppression step per candidate box
//
// A candidate enters on the in_ ports at a clock edge with start high and busy
// low; busy is high only during reset, so one beat can be taken every cycle.
// The best box, class, thresholds and sigma are written on the cfg_ port and
// must stay put while beats are in flight.
// Each beat is scored against the best box: a deep pipeline of areas, union,
// a 16-stage IoU divider, IoU squared, a 26-stage divider by sigma, the exp2
// table step and the score scaling.
// Each accepted beat runs through the stage registers, both dividers and the
// output register; out_valid then strobes for one cycle, carrying new_score,
// touched and the candidate index.
// Throughput is one beat per clock; the two divider pipelines set the depth.
// The receiver cannot stall, so results are never held.
// Synchronous reset empties the pipeline and restores the register defaults
// (IoU threshold one half, everything else zero).
module nms_box_suppress_step_unit #(
  parameter int COORD_BITS = 16,
  parameter int SCORE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [COORD_BITS-1:0]                  in_cand_x1,
  input  logic [COORD_BITS-1:0]                  in_cand_y1,
  input  logic [COORD_BITS-1:0]                  in_cand_x2,
  input  logic [COORD_BITS-1:0]                  in_cand_y2,
  input  logic signed [SCORE_BITS-1:0]           in_cand_score,
  input  logic [nbs_pkg::CLASS_BITS-1:0]         in_cand_class,
  input  logic [nbs_pkg::IDX_BITS-1:0]           in_cand_index,
  output logic                                   out_valid,
  output logic signed [SCORE_BITS-1:0]           out_new_score,
  output logic                                   out_touched,
  output logic [nbs_pkg::IDX_BITS-1:0]           out_out_index,
  input  logic                                   cfg_we,
  input  logic [nbs_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [nbs_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int CW   = (COORD_BITS > 20) ? 20 : COORD_BITS;
  localparam int SH   = COORD_BITS - CW;
  localparam int AW   = 2 * CW + 2;
  localparam int IW   = 2 * CW;
  localparam int UW   = AW + 2;
  localparam int DENW = UW - 1;
  localparam int SW   = SCORE_BITS;
  localparam int IXW  = nbs_pkg::IDX_BITS;
  localparam int SD1  = 3 + SW + IXW;
  localparam int SD2  = 2 + SW + IXW;
  localparam int PW   = SW + 18;
  localparam int LAT  = 4 + nbs_pkg::IOU_BITS + 2 + nbs_pkg::X_BITS + 6;

  // configuration registers
  logic [15:0] best_x1_r, best_y1_r, best_x2_r, best_y2_r;
  logic [nbs_pkg::CLASS_BITS-1:0] best_class_r;
  logic [15:0] iou_thr_r, score_thr_r, sigma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_x1_r    <= '0;
      best_y1_r    <= '0;
      best_x2_r    <= '0;
      best_y2_r    <= '0;
      best_class_r <= '0;
      iou_thr_r    <= nbs_pkg::IOU_THR_RST;
      score_thr_r  <= '0;
      sigma_r      <= '0;
    end else if (cfg_we) begin
      case (nbs_pkg::cfg_idx_t'(cfg_index))
        nbs_pkg::CFG_BEST_X1:    best_x1_r    <= cfg_data;
        nbs_pkg::CFG_BEST_Y1:    best_y1_r    <= cfg_data;
        nbs_pkg::CFG_BEST_X2:    best_x2_r    <= cfg_data;
        nbs_pkg::CFG_BEST_Y2:    best_y2_r    <= cfg_data;
        nbs_pkg::CFG_BEST_CLASS: best_class_r <= cfg_data[nbs_pkg::CLASS_BITS-1:0];
        nbs_pkg::CFG_IOU_THR:    iou_thr_r    <= cfg_data;
        nbs_pkg::CFG_SCORE_THR:  score_thr_r  <= cfg_data;
        nbs_pkg::CFG_SIGMA:      sigma_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = ~rst_n;

  function automatic logic [CW-1:0] ecoord(input logic [COORD_BITS-1:0] v);
    return CW'(v >> SH);
  endfunction

  // stage 1: extents, overlap, tests
  logic [CW-1:0] cx1, cy1, cx2, cy2, bx1, by1, bx2, by2;
  logic [CW-1:0] lx, ly, hx, hy;
  logic signed [SW-1:0] thr_v;
  logic signed [CW:0] dxc_nxt, dyc_nxt, dxb_nxt, dyb_nxt;
  logic [CW-1:0] iw_nxt, ih_nxt;
  logic pass_nxt;

  always_comb begin
    cx1 = ecoord(in_cand_x1);
    cy1 = ecoord(in_cand_y1);
    cx2 = ecoord(in_cand_x2);
    cy2 = ecoord(in_cand_y2);
    bx1 = ecoord(COORD_BITS'(best_x1_r));
    by1 = ecoord(COORD_BITS'(best_y1_r));
    bx2 = ecoord(COORD_BITS'(best_x2_r));
    by2 = ecoord(COORD_BITS'(best_y2_r));
    dxc_nxt = $signed({1'b0, cx2}) - $signed({1'b0, cx1});
    dyc_nxt = $signed({1'b0, cy2}) - $signed({1'b0, cy1});
    dxb_nxt = $signed({1'b0, bx2}) - $signed({1'b0, bx1});
    dyb_nxt = $signed({1'b0, by2}) - $signed({1'b0, by1});
    lx = (cx1 > bx1) ? cx1 : bx1;
    ly = (cy1 > by1) ? cy1 : by1;
    hx = (cx2 < bx2) ? cx2 : bx2;
    hy = (cy2 < by2) ? cy2 : by2;
    iw_nxt = (hx > lx) ? CW'(hx - lx) : '0;
    ih_nxt = (hy > ly) ? CW'(hy - ly) : '0;
    thr_v = SW'(score_thr_r);
    pass_nxt = (in_cand_score > thr_v) && (in_cand_class == best_class_r);
  end

  logic v1_r;
  logic signed [CW:0] dxc_r, dyc_r, dxb_r, dyb_r;
  logic [CW-1:0] iw_r, ih_r;
  logic pass1_r;
  logic signed [SW-1:0] score1_r;
  logic [IXW-1:0] idx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dxc_r    <= dxc_nxt;
    dyc_r    <= dyc_nxt;
    dxb_r    <= dxb_nxt;
    dyb_r    <= dyb_nxt;
    iw_r     <= iw_nxt;
    ih_r     <= ih_nxt;
    pass1_r  <= pass_nxt;
    score1_r <= in_cand_score;
    idx1_r   <= in_cand_index;
  end

  // stage 2: areas and intersection
  logic signed [AW-1:0] ca_nxt, ba_nxt;
  logic [IW-1:0] inter_nxt;
  assign ca_nxt    = AW'(dxc_r) * AW'(dyc_r);
  assign ba_nxt    = AW'(dxb_r) * AW'(dyb_r);
  assign inter_nxt = IW'(iw_r) * IW'(ih_r);

  logic v2_r, pass2_r;
  logic signed [AW-1:0] ca_r, ba_r;
  logic [IW-1:0] inter2_r;
  logic signed [SW-1:0] score2_r;
  logic [IXW-1:0] idx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ca_r     <= ca_nxt;
    ba_r     <= ba_nxt;
    inter2_r <= inter_nxt;
    pass2_r  <= pass1_r;
    score2_r <= score1_r;
    idx2_r   <= idx1_r;
  end

  // stage 3: union
  logic signed [UW-1:0] uni_nxt;
  assign uni_nxt = UW'(ca_r) + UW'(ba_r) - $signed(UW'(inter2_r));

  logic v3_r, pass3_r;
  logic signed [UW-1:0] uni_r;
  logic [IW-1:0] inter3_r;
  logic signed [SW-1:0] score3_r;
  logic [IXW-1:0] idx3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    uni_r    <= uni_nxt;
    inter3_r <= inter2_r;
    pass3_r  <= pass2_r;
    score3_r <= score2_r;
    idx3_r   <= idx2_r;
  end

  // stage 4: empty union and saturation flags
  logic nonpos_nxt, sat_nxt;
  logic [DENW-1:0] den_nxt;
  always_comb begin
    den_nxt    = uni_r[DENW-1:0];
    nonpos_nxt = uni_r[UW-1] || (uni_r == '0);
    sat_nxt    = (DENW+1)'(inter3_r) >= {den_nxt, 1'b0};
  end

  logic v4_r, pass4_r, nonpos4_r, sat4_r;
  logic [DENW-1:0] den4_r;
  logic [IW-1:0] inter4_r;
  logic signed [SW-1:0] score4_r;
  logic [IXW-1:0] idx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    den4_r    <= den_nxt;
    nonpos4_r <= nonpos_nxt;
    sat4_r    <= sat_nxt;
    inter4_r  <= inter3_r;
    pass4_r   <= pass3_r;
    score4_r  <= score3_r;
    idx4_r    <= idx3_r;
  end

  // IoU divider
  logic d1_vld;
  logic [nbs_pkg::IOU_BITS-1:0] d1_quot;
  logic [SD1-1:0] d1_side;

  nbs_div_pipe #(
    .NUM_W  (IW + nbs_pkg::IOU_FRAC),
    .DEN_W  (DENW),
    .Q_W    (nbs_pkg::IOU_BITS),
    .SIDE_W (SD1)
  ) u_iou_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4_r),
    .in_num   ({inter4_r, {nbs_pkg::IOU_FRAC{1'b0}}}),
    .in_den   (den4_r),
    .in_side  ({pass4_r, sat4_r, nonpos4_r, score4_r, idx4_r}),
    .out_vld  (d1_vld),
    .out_quot (d1_quot),
    .out_side (d1_side)
  );

  // stage 5: IoU select, hard test
  logic [nbs_pkg::IOU_BITS-1:0] iou_nxt;
  always_comb begin
    if (d1_side[SD1-3]) begin
      iou_nxt = '0;
    end else if (d1_side[SD1-2]) begin
      iou_nxt = '1;
    end else begin
      iou_nxt = d1_quot;
    end
  end

  logic v5_r, pass5_r, hard5_r;
  logic [nbs_pkg::IOU_BITS-1:0] iou5_r;
  logic signed [SW-1:0] score5_r;
  logic [IXW-1:0] idx5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    iou5_r   <= iou_nxt;
    hard5_r  <= iou_nxt > iou_thr_r;
    pass5_r  <= d1_side[SD1-1];
    score5_r <= d1_side[IXW +: SW];
    idx5_r   <= d1_side[IXW-1:0];
  end

  // stage 6: IoU squared
  logic v6_r, pass6_r, hard6_r;
  logic [nbs_pkg::SQ_BITS-1:0] sq6_r;
  logic signed [SW-1:0] score6_r;
  logic [IXW-1:0] idx6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    sq6_r    <= nbs_pkg::SQ_BITS'(iou5_r) * nbs_pkg::SQ_BITS'(iou5_r);
    pass6_r  <= pass5_r;
    hard6_r  <= hard5_r;
    score6_r <= score5_r;
    idx6_r   <= idx5_r;
  end

  // divide by sigma * 64
  logic d2_vld;
  logic [nbs_pkg::X_BITS-1:0] d2_quot;
  logic [SD2-1:0] d2_side;

  nbs_div_pipe #(
    .NUM_W  (nbs_pkg::SQ_BITS),
    .DEN_W  (nbs_pkg::SIG_DEN_BITS),
    .Q_W    (nbs_pkg::X_BITS),
    .SIDE_W (SD2)
  ) u_sig_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v6_r),
    .in_num   (sq6_r),
    .in_den   ({sigma_r, 6'b0}),
    .in_side  ({pass6_r, hard6_r, score6_r, idx6_r}),
    .out_vld  (d2_vld),
    .out_quot (d2_quot),
    .out_side (d2_side)
  );

  // stage 7: scale by log2(e)
  logic [42:0] yprod;
  assign yprod = 43'(d2_quot) * 43'(nbs_pkg::LOG2E_Q16);

  logic v7_r, pass7_r, hard7_r;
  logic [26:0] y7_r;
  logic signed [SW-1:0] score7_r;
  logic [IXW-1:0] idx7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    y7_r     <= yprod[42:16];
    pass7_r  <= d2_side[SD2-1];
    hard7_r  <= d2_side[SD2-2];
    score7_r <= d2_side[IXW +: SW];
    idx7_r   <= d2_side[IXW-1:0];
  end

  // stage 8: table lookup
  logic [10:0] n8;
  logic [4:0] k8;
  logic [nbs_pkg::W_BITS-1:0] tk8, tk8n;
  assign n8   = y7_r[26:16];
  assign k8   = {1'b0, y7_r[15:12]};
  assign tk8  = nbs_pkg::exp2_q16(k8);
  assign tk8n = nbs_pkg::exp2_q16(k8 + 5'd1);

  logic v8_r, pass8_r, hard8_r, big8_r;
  logic [nbs_pkg::W_BITS-1:0] tk8_r;
  logic [11:0] dk8_r, r8_r;
  logic [4:0] n8_r;
  logic signed [SW-1:0] score8_r;
  logic [IXW-1:0] idx8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    tk8_r    <= tk8;
    dk8_r    <= 12'(tk8 - tk8n);
    r8_r     <= y7_r[11:0];
    n8_r     <= n8[4:0];
    big8_r   <= n8 >= 11'd17;
    pass8_r  <= pass7_r;
    hard8_r  <= hard7_r;
    score8_r <= score7_r;
    idx8_r   <= idx7_r;
  end

  // stage 9: interpolation
  logic [23:0] im9;
  assign im9 = 24'(dk8_r) * 24'(r8_r);

  logic v9_r, pass9_r, hard9_r, big9_r;
  logic [nbs_pkg::W_BITS-1:0] w9_r;
  logic [4:0] n9_r;
  logic signed [SW-1:0] score9_r;
  logic [IXW-1:0] idx9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    w9_r     <= tk8_r - nbs_pkg::W_BITS'(im9 >> 12);
    n9_r     <= n8_r;
    big9_r   <= big8_r;
    pass9_r  <= pass8_r;
    hard9_r  <= hard8_r;
    score9_r <= score8_r;
    idx9_r   <= idx8_r;
  end

  // stage 10: integer part shift
  logic v10_r, pass10_r, hard10_r;
  logic [nbs_pkg::W_BITS-1:0] w10_r;
  logic signed [SW-1:0] score10_r;
  logic [IXW-1:0] idx10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    w10_r     <= big9_r ? '0 : (w9_r >> n9_r);
    pass10_r  <= pass9_r;
    hard10_r  <= hard9_r;
    score10_r <= score9_r;
    idx10_r   <= idx9_r;
  end

  // stage 11: score times weight
  logic signed [PW-1:0] prod11;
  assign prod11 = PW'(score10_r) * PW'($signed({1'b0, w10_r}));

  logic v11_r, pass11_r, hard11_r;
  logic signed [PW-1:0] prod11_r;
  logic signed [SW-1:0] score11_r;
  logic [IXW-1:0] idx11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else begin
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    prod11_r  <= prod11;
    pass11_r  <= pass10_r;
    hard11_r  <= hard10_r;
    score11_r <= score10_r;
    idx11_r   <= idx10_r;
  end

  // stage 12: truncate toward zero and pick the result
  logic signed [PW-1:0] adj12;
  logic signed [SW-1:0] soft12, res12;
  always_comb begin
    adj12  = prod11_r[PW-1] ? (prod11_r + PW'(65535)) : prod11_r;
    soft12 = SW'(adj12 >>> 16);
    if (!pass11_r) begin
      res12 = score11_r;
    end else if (sigma_r == '0) begin
      res12 = hard11_r ? {1'b1, {(SW-1){1'b0}}} : score11_r;
    end else begin
      res12 = soft12;
    end
  end

  logic out_vld_r, out_touched_r;
  logic signed [SW-1:0] out_score_r;
  logic [IXW-1:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    out_score_r   <= res12;
    out_touched_r <= pass11_r;
    out_idx_r     <= idx11_r;
  end

  assign out_valid     = out_vld_r;
  assign out_new_score = out_score_r;
  assign out_touched   = out_touched_r;
  assign out_out_index = out_idx_r;

  // checks
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat did not come out");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted beat");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_out_index == $past(in_cand_index, LAT)))
    else $error("index lost alignment");

  a_untouched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_touched) |-> (out_new_score == $past(in_cand_score, LAT)))
    else $error("untouched score changed");

endmodule
